// File: hdl/ffd_pkg.sv
// shared constants, types and codes of the fixed-length frame deframer
// no dependencies
package ffd_pkg;

	localparam int PAYLOAD_BYTES = 32;
	localparam int FRAME_BYTES   = PAYLOAD_BYTES + 4;
	localparam int ADDR_W        = $clog2(FRAME_BYTES);
	localparam int MEM_DEPTH     = 1 << ADDR_W;
	localparam int FILL_W        = $clog2(FRAME_BYTES + 1);

	localparam logic [7:0] HDR0  = 8'hFF;
	localparam logic [7:0] HDR1  = 8'hFE;
	localparam logic [7:0] TAIL0 = 8'h00;
	localparam logic [7:0] TAIL1 = 8'h01;

	// positions inside a full frame, relative to its first header byte
	localparam logic [FILL_W-1:0] IDX_PAY_FIRST = FILL_W'(2);
	localparam logic [FILL_W-1:0] IDX_PAY_LAST  = FILL_W'(FRAME_BYTES - 3);
	localparam logic [FILL_W-1:0] IDX_TAIL1     = FILL_W'(FRAME_BYTES - 1);
	localparam logic [FILL_W-1:0] FILL_FRAME    = FILL_W'(FRAME_BYTES);
	localparam logic [FILL_W-1:0] FILL_LAST     = FILL_W'(FRAME_BYTES - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EMIT = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       last;
	} emit_t;

endpackage

// File: hdl/ffd_in_if.sv
// input byte channel: valid, ready and one received byte
// no dependencies
interface ffd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// File: hdl/ffd_out_if.sv
// output payload channel: valid, ready, payload byte and end-of-frame mark
// no dependencies
interface ffd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;

	modport source (output valid, output payload_byte, output last_byte, input ready);
	modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

// File: hdl/fixed_length_frame_deframer.sv
// top level of the fixed-length frame deframer: byte channels and output register
// depends on ffd_pkg, ffd_in_if, ffd_out_if, ffd_ctrl
//
// Takes a byte stream on rx and hunts for the header 0xff 0xfe. Once locked it
// gathers a frame of PAYLOAD_BYTES + 4 bytes (header, payload, tail 0x00 0x01).
// On a good tail the payload goes out on tx one item per byte, with last_byte
// set on the final one. On a bad tail only the two header bytes are dropped and
// the rest of the frame is rescanned for a new header, keeping what follows it.
// A trailing 0xff is always kept as a possible header start, so the output does
// not depend on how the stream is split up. Rate: every byte that does not end a
// frame is taken in one cycle. A byte that completes a frame makes the block busy,
// and rx takes no byte until it is done: with a good tail while the payload is
// read out, and longer while tx holds ready low; with a bad tail while the sequencer
// reads the stored frame back through the single read port of the frame store
// and checks byte pairs in one shared compare unit. The store needs no clearing
// after reset.
module fixed_length_frame_deframer
	import ffd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ffd_in_if.sink    rx,
	ffd_out_if.source tx
);

	emit_t      emit;
	logic       slot_free;

	// output register parts the sequencer from tx backpressure
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	assign slot_free = !out_valid_q || tx.ready;

	ffd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx.valid),
		.rx_data   (rx.data_byte),
		.rx_ready  (rx.ready),
		.slot_free (slot_free),
		.emit      (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload holds no reset
	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_data_q <= emit.data;
			out_last_q <= emit.last;
		end
	end

	assign tx.valid        = out_valid_q;
	assign tx.payload_byte = out_data_q;
	assign tx.last_byte    = out_last_q;

endmodule

// File: hdl/ffd_ram.sv
// frame store: circular byte buffer, one write and one registered read port
// depends on ffd_pkg
module ffd_ram
	import ffd_pkg::*;
(
	input  logic       clk,
	input  ram_req_t   req,
	output logic [7:0] rdata
);

	logic [7:0] mem [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// File: hdl/ffd_ctrl.sv
// sequencer of the deframer: header hunt, frame fill, payload readout and rescan
// depends on ffd_pkg and ffd_ram
module ffd_ctrl
	import ffd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic [7:0] rx_data,
	output logic       rx_ready,
	input  logic       slot_free,
	output emit_t      emit
);

	state_t            st_q;
	logic [ADDR_W-1:0] head_q;
	logic [FILL_W-1:0] fill_q;
	logic              locked_q;
	logic [FILL_W-1:0] issue_q;
	logic [FILL_W-1:0] data_idx_q;
	logic              pend_q;
	logic              vld_q;
	logic              prev_ok_q;
	logic [7:0]        prev_q;
	logic [7:0]        last_q;

	ram_req_t          req;
	logic [7:0]        rdata;
	logic              acc;

	// shared pair compare unit
	logic [7:0]        op_a;
	logic [7:0]        op_b;
	logic [7:0]        pat_a;
	logic [7:0]        pat_b;
	logic              pair_hit;
	logic              scan_hit;
	logic              emit_last;
	logic [FILL_W-1:0] hit_pos;

	ffd_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign rx_ready = (st_q == ST_IDLE);
	assign acc      = rx_valid && rx_ready;

	always_comb begin
		if (st_q == ST_SCAN) begin
			op_a  = prev_q;
			op_b  = rdata;
			pat_a = HDR0;
			pat_b = HDR1;
		end else begin
			op_a  = last_q;
			op_b  = rx_data;
			pat_a = locked_q ? TAIL0 : HDR0;
			pat_b = locked_q ? TAIL1 : HDR1;
		end
		pair_hit = (op_a == pat_a) && (op_b == pat_b);
	end

	assign scan_hit  = prev_ok_q && pair_hit;
	assign emit_last = (data_idx_q == IDX_PAY_LAST);
	assign hit_pos   = data_idx_q - FILL_W'(1);

	always_comb begin
		req.we    = acc;
		req.waddr = head_q + fill_q[ADDR_W-1:0];
		req.wdata = rx_data;
		req.raddr = head_q + issue_q[ADDR_W-1:0];
		unique case (st_q)
			ST_EMIT: req.re = !pend_q || (slot_free && !emit_last);
			ST_SCAN: req.re = (issue_q <= IDX_TAIL1) && !(vld_q && scan_hit);
			default: req.re = 1'b0;
		endcase
	end

	assign emit.load = (st_q == ST_EMIT) && pend_q && slot_free;
	assign emit.data = rdata;
	assign emit.last = emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			head_q     <= '0;
			fill_q     <= '0;
			locked_q   <= 1'b0;
			issue_q    <= '0;
			data_idx_q <= '0;
			pend_q     <= 1'b0;
			vld_q      <= 1'b0;
			prev_ok_q  <= 1'b0;
			prev_q     <= '0;
			last_q     <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						last_q <= rx_data;
						if (locked_q) begin
							if (fill_q == FILL_LAST) begin
								issue_q <= IDX_PAY_FIRST;
								if (pair_hit) begin
									st_q   <= ST_EMIT;
									pend_q <= 1'b0;
								end else begin
									st_q      <= ST_SCAN;
									vld_q     <= 1'b0;
									prev_ok_q <= 1'b0;
								end
							end else begin
								fill_q <= fill_q + FILL_W'(1);
							end
						end else if (fill_q == '0) begin
							fill_q <= (rx_data == HDR0) ? FILL_W'(1) : '0;
						end else begin
							// one stored 0xff waits for its second header byte
							if (pair_hit) begin
								locked_q <= 1'b1;
								fill_q   <= FILL_W'(2);
							end else if (rx_data == HDR0) begin
								head_q <= head_q + ADDR_W'(1);
								fill_q <= FILL_W'(1);
							end else begin
								fill_q <= '0;
							end
						end
					end
				end
				ST_EMIT: begin
					if (!pend_q) begin
						pend_q     <= 1'b1;
						data_idx_q <= issue_q;
						issue_q    <= issue_q + FILL_W'(1);
					end else if (slot_free) begin
						if (emit_last) begin
							st_q     <= ST_IDLE;
							pend_q   <= 1'b0;
							fill_q   <= '0;
							locked_q <= 1'b0;
						end else begin
							data_idx_q <= issue_q;
							issue_q    <= issue_q + FILL_W'(1);
						end
					end
				end
				ST_SCAN: begin
					// no read is issued on a hit or after the last byte, so vld_q drops here
					if (req.re) begin
						issue_q    <= issue_q + FILL_W'(1);
						data_idx_q <= issue_q;
						vld_q      <= 1'b1;
					end else begin
						vld_q <= 1'b0;
					end
					if (vld_q) begin
						if (scan_hit) begin
							// new header starts one byte before this one
							head_q   <= head_q + hit_pos[ADDR_W-1:0];
							fill_q   <= FILL_FRAME - hit_pos;
							locked_q <= 1'b1;
							st_q     <= ST_IDLE;
						end else begin
							prev_q    <= rdata;
							prev_ok_q <= 1'b1;
							if (data_idx_q == IDX_TAIL1) begin
								locked_q <= 1'b0;
								st_q     <= ST_IDLE;
								if (rdata == HDR0) begin
									head_q <= head_q + IDX_TAIL1[ADDR_W-1:0];
									fill_q <= FILL_W'(1);
								end else begin
									fill_q <= '0;
								end
							end
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> (fill_q < FILL_FRAME))
		else $error("frame store overfilled while idle");

	a_hunt_fill: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_IDLE) && !locked_q) |-> (fill_q <= FILL_W'(1)))
		else $error("more than one byte kept while hunting");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && locked_q && (fill_q == FILL_LAST)) |=> (st_q != ST_IDLE))
		else $error("full frame not checked");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.load && emit.last) |=> ((st_q == ST_IDLE) && (fill_q == '0) && !locked_q))
		else $error("store not emptied after frame");

endmodule

// File: verif/fixed_length_frame_deframer_tb.sv
// testbench for fixed_length_frame_deframer: byte stream in, checked payload items out
// depends on ffd_pkg, ffd_in_if, ffd_out_if and the deframer rtl
`timescale 1ns / 1ps

module fixed_length_frame_deframer_tb
	import ffd_pkg::*;
();

	// stimulus size and run limits
	localparam int ITEMS       = 230;
	localparam int HOLD_CYCLES = 300;             // long receiver hold-off
	localparam int STALL_LIMIT = 3000;            // cycles with no item moving on either side
	localparam int DRAIN       = 4 * FRAME_BYTES; // covers a bad-tail rescan after the last byte

	// how the payload of a generated frame is filled
	typedef enum int {
		FILL_MIXED,
		FILL_ZERO,
		FILL_ONES
	} payload_fill_t;

	// one expected item on the payload channel
	typedef struct packed {
		logic [7:0] payload;
		logic       last;
	} payload_item_t;

	logic clk;
	logic arst_n;

	ffd_in_if  rx_ch ();
	ffd_out_if tx_ch ();

	fixed_length_frame_deframer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch.sink),
		.tx     (tx_ch.source)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// bytes waiting to be sent, front one is on the bus while valid is high
	logic [7:0]    pending_bytes [$];
	// payload items the deframer must still deliver, oldest first
	payload_item_t expected_payload [$];

	// shadow of the deframer state
	logic [7:0] rx_store [FRAME_BYTES];
	int         rx_fill;
	bit         frame_locked;

	// run control, written at the falling edge by the sequencing block; hold_left by the hold-off counter
	int send_idle_pct;
	int recv_idle_pct;
	bit sender_hold;
	bit hold_req;
	int hold_left;

	// bookkeeping, written at the rising edge by the monitor
	int in_count;
	int stall_cycles;
	int mismatch_count;

	// drop the n oldest bytes of the shadow store
	function automatic void drop_leading(input int n);
		if (n >= rx_fill) begin
			rx_fill = 0;
		end else begin
			for (int i = 0; i < rx_fill - n; i++)
				rx_store[i] = rx_store[i + n];
			rx_fill -= n;
		end
	endfunction

	// take one received byte into the shadow state and queue any payload it releases
	function automatic void deframe_step(input logic [7:0] rx_byte);
		int pos;
		bit settled;
		payload_item_t item;

		if (rx_fill >= FRAME_BYTES)
			rx_fill = 0;
		rx_store[rx_fill] = rx_byte;
		rx_fill++;

		settled = 1'b0;
		while (!settled) begin
			// first header in the store, or rx_fill if none
			pos = rx_fill;
			for (int i = 0; i + 1 < rx_fill; i++)
				if (pos == rx_fill && rx_store[i] == HDR0 && rx_store[i + 1] == HDR1)
					pos = i;

			if (pos >= rx_fill) begin
				// hunting: only a trailing 0xff survives as a header candidate
				if (rx_fill > 0 && rx_store[rx_fill - 1] == HDR0) begin
					rx_store[0] = HDR0;
					rx_fill = 1;
				end else begin
					rx_fill = 0;
				end
				frame_locked = 1'b0;
				settled = 1'b1;
			end else begin
				// junk in front of the header is discarded
				drop_leading(pos);
				frame_locked = 1'b1;
				if (rx_fill < FRAME_BYTES) begin
					settled = 1'b1;
				end else if (rx_store[FRAME_BYTES - 2] == TAIL0 &&
				             rx_store[FRAME_BYTES - 1] == TAIL1) begin
					for (int i = 0; i < PAYLOAD_BYTES; i++) begin
						item.payload = rx_store[2 + i];
						item.last    = (i == PAYLOAD_BYTES - 1);
						expected_payload.push_back(item);
					end
					drop_leading(FRAME_BYTES);
					frame_locked = 1'b0;
					settled = 1'b1;
				end else begin
					// bad tail: lose the header only, rescan the rest
					drop_leading(2);
				end
			end
		end
	endfunction

	// random byte biased toward the header and tail values
	function automatic logic [7:0] stream_byte();
		case ($urandom_range(7))
			0: return HDR0;
			1: return HDR1;
			2: return TAIL0;
			3: return TAIL1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// queue a whole frame with the given tail
	function automatic void queue_frame(input logic [7:0] t0, input logic [7:0] t1,
	                                    input payload_fill_t fill);
		pending_bytes.push_back(HDR0);
		pending_bytes.push_back(HDR1);
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			case (fill)
				FILL_ZERO: pending_bytes.push_back(8'h00);
				FILL_ONES: pending_bytes.push_back(8'hFF);
				default:   pending_bytes.push_back(stream_byte());
			endcase
		end
		pending_bytes.push_back(t0);
		pending_bytes.push_back(t1);
	endfunction

	// driver: offers the front pending byte, holds it until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid     <= 1'b0;
			rx_ch.data_byte <= 8'h00;
		end else begin
			if (rx_ch.valid && rx_ch.ready)
				void'(pending_bytes.pop_front());
			if (!rx_ch.valid || rx_ch.ready) begin
				if (pending_bytes.size() != 0 && !sender_hold &&
				    $urandom_range(99) >= send_idle_pct) begin
					rx_ch.valid     <= 1'b1;
					rx_ch.data_byte <= pending_bytes[0];
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver hold-off counter, loaded once on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: predicts on every byte taken, then checks every payload item delivered
	always @(posedge clk or negedge arst_n) begin : monitor
		payload_item_t want;
		bit moved;

		if (!arst_n) begin
			tx_ch.ready  <= 1'b0;
			stall_cycles = 0;
		end else begin
			moved = 1'b0;

			// prediction first, so an item released on this edge is already queued
			if (rx_ch.valid && rx_ch.ready) begin
				deframe_step(rx_ch.data_byte);
				in_count++;
				moved = 1'b1;
			end

			if (tx_ch.valid && tx_ch.ready) begin
				moved = 1'b1;
				if (expected_payload.size() == 0) begin
					$error("payload_byte: expected no item, actual %02h",
					       tx_ch.payload_byte);
					mismatch_count++;
				end else begin
					want = expected_payload.pop_front();
					if (tx_ch.payload_byte !== want.payload) begin
						$error("payload_byte: expected %02h, actual %02h",
						       want.payload, tx_ch.payload_byte);
						mismatch_count++;
					end
					if (tx_ch.last_byte !== want.last) begin
						$error("last_byte: expected %0b, actual %0b",
						       want.last, tx_ch.last_byte);
						mismatch_count++;
					end
				end
			end

			tx_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);

			// watchdog on cycles where nothing moves on either channel
			if (moved)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// stimulus build and run sequencing
	initial begin
		int total;
		int pick;
		int span;
		logic [7:0] t0;
		logic [7:0] t1;

		arst_n          = 1'b0;
		rx_ch.valid     = 1'b0;
		rx_ch.data_byte = 8'h00;
		tx_ch.ready     = 1'b0;
		send_idle_pct   = 18;
		recv_idle_pct   = 73;
		sender_hold     = 1'b0;
		hold_req        = 1'b0;
		in_count        = 0;
		mismatch_count  = 0;
		rx_fill         = 0;
		frame_locked    = 1'b0;

		// directed hunting: lone tail and header bytes, a 0xff that is not last,
		// a run of 0xff, and a trailing 0xff that must be kept as a header start
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(HDR1);
		pending_bytes.push_back(TAIL1);
		pending_bytes.push_back(HDR0);
		pending_bytes.push_back(8'h5A);
		pending_bytes.push_back(HDR0);
		pending_bytes.push_back(HDR0);
		pending_bytes.push_back(HDR0);
		pending_bytes.push_back(8'hA5);
		pending_bytes.push_back(8'hFF);

		// random part: mostly well formed frames, mixed with broken ones and line noise
		while (pending_bytes.size() < ITEMS - 2 * FRAME_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				queue_frame(TAIL0, TAIL1, FILL_MIXED);
			end else if (pick < 55) begin
				queue_frame(TAIL0, TAIL1,
				            payload_fill_t'(($urandom_range(1) != 0) ? FILL_ONES : FILL_ZERO));
			end else if (pick < 70) begin
				// bad tail, never equal to the good one
				t0 = stream_byte();
				t1 = stream_byte();
				if (t0 == TAIL0 && t1 == TAIL1)
					t1 = 8'h02;
				queue_frame(t0, t1, FILL_MIXED);
			end else if (pick < 85) begin
				// header, a few bytes, then a good frame inside the first one's window:
				// the rescan after the outer bad tail must find and keep it
				pending_bytes.push_back(HDR0);
				pending_bytes.push_back(HDR1);
				span = $urandom_range(29);
				repeat (span) pending_bytes.push_back(stream_byte());
				queue_frame(TAIL0, TAIL1, FILL_MIXED);
			end else if (pick < 95) begin
				span = $urandom_range(6, 1);
				repeat (span) pending_bytes.push_back(stream_byte());
			end else begin
				// truncated frame running into the next one
				pending_bytes.push_back(HDR0);
				pending_bytes.push_back(HDR1);
				span = $urandom_range(20, 1);
				repeat (span) pending_bytes.push_back(stream_byte());
			end
		end
		// two good frames at the payload extremes close the stream
		queue_frame(TAIL0, TAIL1, FILL_ZERO);
		queue_frame(TAIL0, TAIL1, FILL_ONES);
		total = pending_bytes.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// swap the idling of sender and receiver after the first third
		while (in_count < total / 3) @(negedge clk);
		send_idle_pct = 73;
		recv_idle_pct = 18;

		// sender stops until every expected item has come out
		while (in_count < total / 2) @(negedge clk);
		sender_hold = 1'b1;
		while (expected_payload.size() != 0) @(negedge clk);
		sender_hold = 1'b0;

		// last third runs without idling
		while (in_count < 2 * total / 3) @(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// once a frame is being emitted, hold the receiver off so the input backs up
		while (expected_payload.size() == 0 && in_count < total) @(negedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		hold_req = 1'b0;

		while (in_count < total || expected_payload.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);

		if (mismatch_count == 0 && expected_payload.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
hdl/ffd_pkg.sv
hdl/ffd_in_if.sv
hdl/ffd_out_if.sv
hdl/ffd_ram.sv
hdl/ffd_ctrl.sv
hdl/fixed_length_frame_deframer.sv
verif/fixed_length_frame_deframer_tb.sv
